[hw/rtl/per_source_window_rate_limiter_macros.svh]
// ----------------------------------------------------------------------------
// Per-source window rate limiter: assertion macros
// Shorthand for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_SOURCE_WINDOW_RATE_LIMITER_MACROS_SVH

// Assertion sampled on clk_i, switched off while rst_ni is low.
`define PSWRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion sampled on clk_i that is also checked during reset.
`define PSWRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/pswrl_pkg.sv]
// ----------------------------------------------------------------------------
// pswrl_pkg
// Shared types, constants and helpers of the per-source window rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pswrl_pkg;

  // Number of tracked sources.
  localparam int unsigned Slots = 8;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;

  // Depth of the queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned KeyW   = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CountW = CfgW + 1;
  localparam int unsigned IdxW   = 3;

  // Configuration register indexes.
  localparam logic CfgMaxRate      = 1'b0;
  localparam logic CfgWindowLength = 1'b1;

  localparam logic [CfgW-1:0] MaxRateReset      = 16'd200;
  localparam logic [CfgW-1:0] WindowLengthReset = 16'd1000;

  typedef enum logic {
    CMD_CHECK = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_LOOK = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e             command;
    logic [KeyW-1:0]  source_key;
    logic [TimeW-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic            accepted;
    logic            tracked;
    logic [IdxW-1:0] slot_index;
  } res_t;

  // Slot number modulo 8, zero-extended when the slot index is narrower.
  function automatic logic [IdxW-1:0] to_slot_index(input logic [SlotW-1:0] idx);
    logic [SlotW+IdxW-1:0] ext;
    ext = {{IdxW{1'b0}}, idx};
    return ext[IdxW-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pswrl_front.sv]
// ----------------------------------------------------------------------------
// pswrl_front
// Accepts command transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pswrl_front
  import pswrl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             command_i,
  input  wire logic [KeyW-1:0]  source_key_i,
  input  wire logic [TimeW-1:0] time_ms_i,
  output item_t                 head_o,
  output logic                  head_valid_o,
  input  wire logic             pop_i
);

  item_t              mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               push;
  logic               pop;
  item_t              in_item;

  assign busy         = (cnt_q == QCntW'(QDepth));
  assign push         = start && !busy;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    in_item.command    = (command_i == 1'b1) ? CMD_CLEAR : CMD_CHECK;
    in_item.source_key = source_key_i;
    in_item.time_ms    = time_ms_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[hw/rtl/pswrl_back.sv]
// ----------------------------------------------------------------------------
// pswrl_back
// Slot table: key lookup, window check and count update, one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pswrl_back
  import pswrl_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire item_t           head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  input  wire logic [CfgW-1:0] max_rate_i,
  input  wire logic [CfgW-1:0] window_length_i,
  output res_t                 res_o,
  output logic                 res_valid_o
);

  state_e state_q, state_d;

  logic [Slots-1:0] valid_q;
  logic [KeyW-1:0]  key_q   [Slots];
  logic [TimeW-1:0] start_q [Slots];
  logic [CountW-1:0] count_q [Slots];

  item_t            item_q;
  logic             hit_q, free_q;
  logic [SlotW-1:0] idx_q;

  logic             hit_d, free_d;
  logic [SlotW-1:0] hit_idx, free_idx;

  logic [TimeW-1:0]  elapsed;
  logic              restart;
  logic [CountW-1:0] cnt_base, cnt_next, limit;
  logic              use_slot;
  logic              is_clear;
  logic              exec;

  res_t res_q;
  logic res_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOOK: begin
        if (head_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_LOOK;
      default: state_d = ST_LOOK;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o = 1'b0;
    exec  = 1'b0;
    case (state_q)
      ST_LOOK: pop_o = head_valid_i;
      ST_EXEC: exec  = 1'b1;
      default: begin
        pop_o = 1'b0;
        exec  = 1'b0;
      end
    endcase
  end

  // Parallel key compare; walk downward so the lowest match and free slot win.
  always_comb begin
    hit_d    = 1'b0;
    free_d   = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (valid_q[i]) begin
        if (key_q[i] == head_i.source_key) begin
          hit_d   = 1'b1;
          hit_idx = SlotW'(i);
        end
      end else begin
        free_d   = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
      hit_q  <= hit_d;
      free_q <= free_d;
      idx_q  <= hit_d ? hit_idx : free_idx;
    end
  end

  // Window check and count update on the selected slot.
  always_comb begin
    is_clear = (item_q.command == CMD_CLEAR);
    use_slot = hit_q || free_q;
    elapsed  = item_q.time_ms - start_q[idx_q];
    restart  = !hit_q || (elapsed >= {{(TimeW-CfgW){1'b0}}, window_length_i});
    cnt_base = restart ? '0 : count_q[idx_q];
    limit    = {1'b0, max_rate_i} + CountW'(1);
    cnt_next = (cnt_base < limit) ? cnt_base + CountW'(1) : cnt_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOOK;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= exec;
      if (exec) begin
        if (is_clear) begin
          valid_q <= '0;
        end else if (use_slot) begin
          valid_q[idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && !is_clear && use_slot) begin
      key_q[idx_q]   <= item_q.source_key;
      count_q[idx_q] <= cnt_next;
      if (restart) begin
        start_q[idx_q] <= item_q.time_ms;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      if (is_clear) begin
        res_q <= '0;
      end else if (!use_slot) begin
        // Table full: pass untracked.
        res_q.accepted   <= 1'b1;
        res_q.tracked    <= 1'b0;
        res_q.slot_index <= '0;
      end else begin
        res_q.accepted   <= (cnt_next <= {1'b0, max_rate_i});
        res_q.tracked    <= 1'b1;
        res_q.slot_index <= to_slot_index(idx_q);
      end
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

[hw/rtl/per_source_window_rate_limiter.sv]
// An accepted transaction is written into the queue, popped into the slot table's lookup state
// and updated in its execute state, which registers the result; earlier queue entries go first.
// The slot table ends the lookup and update steps of one transaction before it takes the next.
// A 2-entry queue takes up to two transactions ahead; busy is high while it is full.
// Results are strobed for one cycle on result_valid_o; the receiver cannot stall.
// Reset frees every slot and loads max_rate 200 and window_length 1000.
// ----------------------------------------------------------------------------
// per_source_window_rate_limiter
// Per-source fixed-window event rate limiter with a shared slot table.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_window_rate_limiter
  import pswrl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             command_i,
  input  wire logic [KeyW-1:0]  source_key_i,
  input  wire logic [TimeW-1:0] time_ms_i,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  output logic                  result_valid_o,
  output logic                  accepted_o,
  output logic                  tracked_o,
  output logic [IdxW-1:0]       slot_index_o
);

  logic [CfgW-1:0] max_rate_q, window_length_q;
  item_t           head;
  logic            head_valid;
  logic            pop;
  res_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q      <= MaxRateReset;
      window_length_q <= WindowLengthReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxRate:      max_rate_q      <= cfg_wdata_i;
        CfgWindowLength: window_length_q <= cfg_wdata_i;
        default:         max_rate_q      <= max_rate_q;
      endcase
    end
  end

  pswrl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .source_key_i (source_key_i),
    .time_ms_i    (time_ms_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  pswrl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .max_rate_i      (max_rate_q),
    .window_length_i (window_length_q),
    .res_o           (res),
    .res_valid_o     (result_valid_o)
  );

  assign accepted_o   = res.accepted;
  assign tracked_o    = res.tracked;
  assign slot_index_o = res.slot_index;

endmodule

`default_nettype wire

[hw/rtl/pswrl_checker.sv]
// ----------------------------------------------------------------------------
// pswrl_checker
// Port-level checks of the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_source_window_rate_limiter_macros.svh"

module pswrl_checker
  import pswrl_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             result_valid_o,
  input wire logic             accepted_o,
  input wire logic             tracked_o,
  input wire logic [IdxW-1:0]  slot_index_o
);

  logic [IdxW+1:0] res_bits;

  assign res_bits = {accepted_o, tracked_o, slot_index_o};

  // Each transaction passes a lookup and an update state, so strobes never touch.
  `PSWRL_ASSERT(a_strobe_gap, result_valid_o |=> !result_valid_o, "back-to-back result strobes")

  // An untracked result names no slot.
  `PSWRL_ASSERT(a_untracked_idx, (result_valid_o && !tracked_o) |-> (slot_index_o == '0), "untracked slot")

  // Every strobed result carries known fields.
  `PSWRL_ASSERT(a_result_known, result_valid_o |-> !$isunknown(res_bits), "result fields unknown")

  // No result may come out of reset.
  `PSWRL_ASSERT_ALWAYS(a_reset_quiet, (!rst_ni || !$past(rst_ni)) |-> !result_valid_o, "result strobe during reset")

endmodule

bind per_source_window_rate_limiter pswrl_checker u_checker (.*);

`default_nettype wire

[sim/tb_per_source_window_rate_limiter.sv]
// ----------------------------------------------------------------------------
// tb_per_source_window_rate_limiter
// Self-checking bench for the per-source window rate limiter. A queue-fed
// driver sends bursty event and clear transactions, and a behavioral slot
// table predicts each verdict. The monitor matches every result strobe,
// field by field, against the oldest prediction. Phases step the max rate
// and the window length through their extremes and some values in between.
// ----------------------------------------------------------------------------

module tb_per_source_window_rate_limiter;
  import pswrl_pkg::*;

  localparam int unsigned CycleLimit = 200_000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start = 1'b0;
  logic             busy;
  logic             command_i = CMD_CHECK;
  logic [KeyW-1:0]  source_key_i = '0;
  logic [TimeW-1:0] time_ms_i = '0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = CfgMaxRate;
  logic [CfgW-1:0]  cfg_wdata_i = '0;
  logic             result_valid_o;
  logic             accepted_o;
  logic             tracked_o;
  logic [IdxW-1:0]  slot_index_o;

  per_source_window_rate_limiter dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .command_i,
    .source_key_i,
    .time_ms_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .result_valid_o,
    .accepted_o,
    .tracked_o,
    .slot_index_o
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the slot table and the two registers.
  logic              slot_live  [Slots];
  logic [KeyW-1:0]   slot_src   [Slots];
  logic [TimeW-1:0]  slot_since [Slots];
  logic [CountW-1:0] slot_hits  [Slots];
  logic [CfgW-1:0]   lim_rate = MaxRateReset;
  logic [CfgW-1:0]   win_len  = WindowLengthReset;

  item_t event_backlog   [$];
  res_t  pending_verdicts[$];
  item_t on_port;
  int    burst_left = 0;
  int    gap_left   = 0;

  int n_events = 0, n_clear = 0, n_untracked = 0, n_rejected = 0;
  int n_restart = 0, n_saturated = 0, n_results = 0, faults = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_live[i] = 1'b0;
      slot_hits[i] = '0;
    end
  end

  // Verdict of one transaction; updates the shadow table as the block would.
  function automatic res_t rate_decision(input item_t ev);
    int hit;
    int vacant;
    logic [TimeW-1:0] elapsed;
    res_t r;
    hit = -1;
    vacant = -1;
    r = '0;
    n_events++;
    if (ev.command == CMD_CLEAR) begin
      for (int i = 0; i < Slots; i++) begin
        slot_live[i] = 1'b0;
        slot_hits[i] = '0;
      end
      n_clear++;
      return r;
    end
    for (int i = 0; i < Slots; i++) begin
      if (slot_live[i]) begin
        if (hit < 0 && slot_src[i] == ev.source_key) hit = i;
      end else if (vacant < 0) begin
        vacant = i;
      end
    end
    if (hit < 0) begin
      // table full: pass untracked
      if (vacant < 0) begin
        r.accepted = 1'b1;
        n_untracked++;
        return r;
      end
      hit = vacant;
      slot_live[hit]  = 1'b1;
      slot_src[hit]   = ev.source_key;
      slot_hits[hit]  = '0;
      slot_since[hit] = ev.time_ms;
    end
    elapsed = ev.time_ms - slot_since[hit];
    if (elapsed >= TimeW'(win_len)) begin
      slot_since[hit] = ev.time_ms;
      slot_hits[hit]  = '0;
      n_restart++;
    end
    if (slot_hits[hit] < CountW'(lim_rate) + CountW'(1)) slot_hits[hit]++;
    else n_saturated++;
    r.accepted   = (slot_hits[hit] <= CountW'(lim_rate));
    r.tracked    = 1'b1;
    r.slot_index = IdxW'(hit);
    if (!r.accepted) n_rejected++;
    return r;
  endfunction

  function automatic item_t mk_event(input cmd_e c, input logic [KeyW-1:0] k,
                                     input logic [TimeW-1:0] t);
    item_t ev;
    ev.command    = c;
    ev.source_key = k;
    ev.time_ms    = t;
    return ev;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) pending_verdicts.push_back(rate_decision(on_port));
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (event_backlog.size() != 0) begin
          on_port = event_backlog.pop_front();
          start        <= 1'b1;
          command_i    <= on_port.command;
          source_key_i <= on_port.source_key;
          time_ms_i    <= on_port.time_ms;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic flag_fault(input string msg);
    faults++;
    if (faults <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Results cannot be held off: check every strobe as it comes.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      n_results++;
      if (pending_verdicts.size() == 0) begin
        flag_fault($sformatf("unexpected result acc=%0b trk=%0b slot=%0d",
                             accepted_o, tracked_o, slot_index_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (accepted_o !== want.accepted || tracked_o !== want.tracked ||
            slot_index_o !== want.slot_index)
          flag_fault($sformatf("acc exp %0b got %0b, trk exp %0b got %0b, slot exp %0d got %0d",
                               want.accepted, accepted_o, want.tracked, tracked_o,
                               want.slot_index, slot_index_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d predictions open", cycle_count,
               pending_verdicts.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CfgMaxRate) lim_rate = val;
    else win_len = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [CfgW-1:0] rate, input logic [CfgW-1:0] win);
    write_reg(CfgMaxRate, rate);
    write_reg(CfgWindowLength, win);
    @(negedge clk_i);
  endtask

  // Hold until every queued transaction is taken and every result checked.
  task automatic settle();
    while (event_backlog.size() != 0 || start || pending_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [CfgW-1:0] rate, input logic [CfgW-1:0] win,
                           input int count);
    int pool_n;
    int w;
    int r;
    int s;
    logic [KeyW-1:0]  pool[$];
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] clock_ms;
    configure(rate, win);
    w = win;
    pool_n = $urandom_range(3, 12);
    for (int i = 0; i < pool_n; i++) pool.push_back($urandom);
    // near-miss key: one bit away from another source
    pool[1] = pool[0] ^ (32'h1 << $urandom_range(0, 31));
    clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4 * w + 8)
                                           : $urandom;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (s < 65)      clock_ms += $urandom_range(0, w / 8 + 1);
      else if (s < 88) clock_ms += $urandom_range(0, 2 * w + 2);
      else if (s < 94) clock_ms = $urandom;
      else             clock_ms -= $urandom_range(1, w + 1);
      key = (r < 10) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
      if (r < 3) event_backlog.push_back(mk_event(CMD_CLEAR, $urandom, $urandom));
      else event_backlog.push_back(mk_event(CMD_CHECK, key, clock_ms));
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: fill the table, overflow it, probe window edges and wrap.
    event_backlog.push_back(mk_event(CMD_CHECK, 32'h0000_0000, 32'h0000_0000));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    for (int k = 1; k <= 6; k++) event_backlog.push_back(mk_event(CMD_CHECK, k, 32'd10));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'hA5A5_5A5A, 32'd20));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'h0000_0000, 32'd999));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'h0000_0000, 32'd1000));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'hFFFF_FFFF, 32'd998));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'hFFFF_FFFF, 32'd999));
    event_backlog.push_back(mk_event(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'hA5A5_5A5A, 32'd30));
    settle();

    // Zero rate and zero window: every event restarts and is rejected.
    configure('0, '0);
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd7, 32'd0));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd7, 32'd0));
    settle();

    // Rate of one over the widest window: saturate, then restart twice.
    configure(16'd1, 16'hFFFF);
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd9, 32'd100));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd9, 32'd101));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd9, 32'd102));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd9, 32'd100 + 32'hFFFF));
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd9, 32'd50));
    settle();

    configure(16'hFFFF, 16'd1);
    event_backlog.push_back(mk_event(CMD_CHECK, 32'd3, 32'd0));
    event_backlog.push_back(mk_event(CMD_CLEAR, 32'd0, 32'd0));
    settle();

    run_phase(MaxRateReset, WindowLengthReset, 60);
    run_phase(16'd1, 16'd40, 60);
    run_phase(16'd0, 16'd500, 60);
    run_phase(16'd3, 16'd0, 60);
    run_phase(16'd2, 16'hFFFF, 60);
    run_phase(16'hFFFF, 16'hFFFF, 60);
    run_phase(16'd4, 16'd100, 60);
    run_phase(16'd1, 16'd1, 60);
    run_phase(CfgW'($urandom_range(1, 8)), CfgW'($urandom_range(1, 300)), 60);

    settle();
    repeat (8) @(posedge clk_i);
    $display("%0d transactions, %0d results: %0d clears, %0d untracked, %0d rejected",
             n_events, n_results, n_clear, n_untracked, n_rejected);
    $display("%0d window restarts, %0d saturated counts, %0d mismatches",
             n_restart, n_saturated, faults);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
